>>> hw/rtl/utf8_decode_han_detect_assert.svh
// Assertion macros for the UTF-8 decoder RTL; included by utf8dh_emit.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef UTF8_DECODE_HAN_DETECT_ASSERT_SVH
`define UTF8_DECODE_HAN_DETECT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define UTF8DH_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UTF8DH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define UTF8DH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/utf8dh_pkg.sv
// Shared constants, types and the Han range check for the UTF-8 decoder.
// No dependencies; used by every module of the block.
package utf8dh_pkg;

	localparam int ByteW      = 8;
	localparam int CpW        = 21;
	localparam int CntW       = 3;
	localparam int MaxResults = 4;
	localparam int DataW      = ((CpW + 7) / 8) * 8;
	localparam int UserW      = 3;

	localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

	// Han ranges: CJK extension A, unified ideographs, compatibility, extension B.
	localparam logic [CpW-1:0] HanALo = 21'h003400;
	localparam logic [CpW-1:0] HanAHi = 21'h004DBF;
	localparam logic [CpW-1:0] HanULo = 21'h004E00;
	localparam logic [CpW-1:0] HanUHi = 21'h009FFF;
	localparam logic [CpW-1:0] HanCLo = 21'h00F900;
	localparam logic [CpW-1:0] HanCHi = 21'h00FAFF;
	localparam logic [CpW-1:0] HanBLo = 21'h020000;
	localparam logic [CpW-1:0] HanBHi = 21'h02A6DF;

	// Byte class masks and patterns.
	localparam logic [ByteW-1:0] ContMask  = 8'hC0;
	localparam logic [ByteW-1:0] ContByte  = 8'h80;
	localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
	localparam logic [ByteW-1:0] Lead2Byte = 8'hC0;
	localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
	localparam logic [ByteW-1:0] Lead3Byte = 8'hE0;
	localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
	localparam logic [ByteW-1:0] Lead4Byte = 8'hF0;

	// Results planned for one input byte: replacement beats, then an optional tail.
	typedef struct packed {
		logic [CntW-1:0] cnt;
		logic            has_tail;
		logic [CpW-1:0]  tail_cp;
		logic            tail_han;
		logic            eot;
		logic            seen_old;
	} plan_t;

	function automatic logic han_range(input logic [CpW-1:0] cp);
		han_range = (cp >= HanALo && cp <= HanAHi) ||
		            (cp >= HanULo && cp <= HanUHi) ||
		            (cp >= HanCLo && cp <= HanCHi) ||
		            (cp >= HanBLo && cp <= HanBHi);
	endfunction

endpackage

>>> hw/rtl/utf8dh_decode.sv
// Byte decoder: holds the open-sequence state and plans the results of one byte.
// Depends on utf8dh_pkg.
module utf8dh_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [utf8dh_pkg::ByteW-1:0]  text_byte,
	input  logic                          eot,
	input  logic                          consume,
	output utf8dh_pkg::plan_t             plan
);
	import utf8dh_pkg::*;

	typedef enum logic [2:0] {
		LK_ASCII,
		LK_SEQ2,
		LK_SEQ3,
		LK_SEQ4,
		LK_BAD
	} lead_kind_t;

	logic [1:0]      pend_q, pend_d;
	logic [2:0]      seqlen_q, seqlen_d;
	logic [CpW-1:0]  partial_q, partial_d;
	logic            seen_q, seen_d;

	logic [2:0]      pend_inc;
	logic [CpW-1:0]  cont_code;
	logic            is_cont;
	logic            started;
	logic [CntW-1:0] flush_cnt;
	logic            has_tail;
	logic [CpW-1:0]  tail_cp;
	logic            tail_han;
	lead_kind_t      kind;

	// Classify the byte as a lead.
	always_comb begin
		if (text_byte[ByteW-1] == 1'b0) begin
			kind = LK_ASCII;
		end else if ((text_byte & Lead2Mask) == Lead2Byte) begin
			kind = LK_SEQ2;
		end else if ((text_byte & Lead3Mask) == Lead3Byte) begin
			kind = LK_SEQ3;
		end else if ((text_byte & Lead4Mask) == Lead4Byte) begin
			kind = LK_SEQ4;
		end else begin
			kind = LK_BAD;
		end
	end

	// Plan the results and the next sequence state.
	always_comb begin
		pend_inc  = {1'b0, pend_q} + 3'd1;
		cont_code = {partial_q[CpW-7:0], text_byte[5:0]};
		is_cont   = (text_byte & ContMask) == ContByte;
		started   = 1'b0;
		flush_cnt = '0;
		has_tail  = 1'b0;
		tail_cp   = cont_code;
		pend_d    = pend_q;
		seqlen_d  = seqlen_q;
		partial_d = partial_q;

		if (pend_q != 2'd0 && is_cont) begin
			if (pend_inc >= seqlen_q) begin
				// The continuation completes the sequence.
				has_tail  = 1'b1;
				pend_d    = '0;
				seqlen_d  = '0;
				partial_d = '0;
			end else begin
				pend_d    = pend_inc[1:0];
				partial_d = cont_code;
				if (eot) begin
					flush_cnt = pend_inc;
				end
			end
		end else begin
			// Any open sequence is broken; the byte is then taken as a lead.
			flush_cnt = {1'b0, pend_q};
			pend_d    = '0;
			seqlen_d  = '0;
			partial_d = '0;
			unique case (kind)
				LK_ASCII: begin
					has_tail = 1'b1;
					tail_cp  = {{(CpW-ByteW){1'b0}}, text_byte};
				end
				LK_SEQ2: begin
					started   = 1'b1;
					pend_d    = 2'd1;
					seqlen_d  = 3'd2;
					partial_d = {{(CpW-5){1'b0}}, text_byte[4:0]};
				end
				LK_SEQ3: begin
					started   = 1'b1;
					pend_d    = 2'd1;
					seqlen_d  = 3'd3;
					partial_d = {{(CpW-4){1'b0}}, text_byte[3:0]};
				end
				LK_SEQ4: begin
					started   = 1'b1;
					pend_d    = 2'd1;
					seqlen_d  = 3'd4;
					partial_d = {{(CpW-3){1'b0}}, text_byte[2:0]};
				end
				default: begin
					has_tail = 1'b1;
					tail_cp  = Replacement;
				end
			endcase
			if (started && eot) begin
				flush_cnt = flush_cnt + 3'd1;
			end
		end

		// The end of the text clears everything.
		if (eot) begin
			pend_d    = '0;
			seqlen_d  = '0;
			partial_d = '0;
		end

		tail_han = has_tail && han_range(tail_cp);
		seen_d   = eot ? 1'b0 : (seen_q | tail_han);

		plan.cnt      = flush_cnt + {{(CntW-1){1'b0}}, has_tail};
		plan.has_tail = has_tail;
		plan.tail_cp  = tail_cp;
		plan.tail_han = tail_han;
		plan.eot      = eot;
		plan.seen_old = seen_q;
	end

	// Sequence state advances when the byte is handed to the emitter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			seqlen_q  <= '0;
			partial_q <= '0;
			seen_q    <= 1'b0;
		end else if (consume) begin
			pend_q    <= pend_d;
			seqlen_q  <= seqlen_d;
			partial_q <= partial_d;
			seen_q    <= seen_d;
		end
	end

endmodule

>>> hw/rtl/utf8dh_emit.sv
// Result register: plays out a byte's planned results, one beat a cycle while ready.
// Depends on utf8dh_pkg and utf8_decode_han_detect_assert.svh.
`include "utf8_decode_han_detect_assert.svh"

module utf8dh_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  utf8dh_pkg::plan_t             plan,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [utf8dh_pkg::DataW-1:0]  m_tdata,  // code_point
	output logic                          m_tlast,  // last_of_run
	output logic [utf8dh_pkg::UserW-1:0]  m_tuser   // is_han, text_has_han, text_done
);
	import utf8dh_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic            has_tail_q;
	logic [CpW-1:0]  tail_cp_q;
	logic            tail_han_q;
	logic            eot_q;
	logic            seen_old_q;

	logic            fire;
	logic            last;
	logic            is_tail;
	logic [CpW-1:0]  code;

	assign fire    = m_tvalid && m_tready;
	assign last    = cnt_q == CntW'(1);
	assign free    = (cnt_q == '0) || (fire && last);
	assign is_tail = has_tail_q && last;
	assign code    = is_tail ? tail_cp_q : Replacement;

	// Output beat: replacements first, then the tail result.
	assign m_tvalid   = cnt_q != '0;
	assign m_tdata    = {{(DataW-CpW){1'b0}}, code};
	assign m_tlast    = last;
	assign m_tuser[0] = is_tail && tail_han_q;
	assign m_tuser[1] = seen_old_q || (is_tail && tail_han_q);
	assign m_tuser[2] = last && eot_q;

	// Remaining beat count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= plan.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	// Payload of the current byte's results.
	always_ff @(posedge clk) begin
		if (load) begin
			has_tail_q <= plan.has_tail;
			tail_cp_q  <= plan.tail_cp;
			tail_han_q <= plan.tail_han;
			eot_q      <= plan.eot;
			seen_old_q <= plan.seen_old;
		end
	end

	`UTF8DH_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(MaxResults), "beat count out of range")
	`UTF8DH_ASSERT_SAME(a_han_on_last, m_tvalid && m_tuser[0], m_tlast, "Han flag before last beat")
	`UTF8DH_ASSERT_SAME(a_done_on_last, m_tvalid && m_tuser[2], m_tlast, "text end before last beat")
	`UTF8DH_ASSERT_NEXT(a_no_reload, fire && !last, cnt_q == $past(cnt_q) - CntW'(1),
		"job reloaded before its last beat")

endmodule

>>> hw/rtl/utf8_decode_han_detect.sv
// Top level of the streaming UTF-8 decoder with Han detection.
// Depends on utf8dh_pkg, utf8dh_decode and utf8dh_emit.

// The block takes one text byte per beat (tlast marks the final byte of a text) and
// returns the decoded code points, one per beat, with a Han flag, a running any-Han
// flag and an end-of-text flag in tuser; tlast marks the last result caused by a
// byte. A byte that produces no result or one result does not hold up the input,
// so plain text streams at one byte per cycle while m_tready is high. A byte that
// produces n results (up to four, when a broken sequence is flushed) holds the
// result register until all n are taken, which sets the rate. An accepted byte
// enters the input register, or the skid entry first if that is full, then the
// result register. A two-entry skid buffer on the input keeps tready registered.
module utf8_decode_han_detect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [utf8dh_pkg::ByteW-1:0]  s_tdata,   // text_byte
	input  logic                          s_tlast,   // end_of_text
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [utf8dh_pkg::DataW-1:0]  m_tdata,   // code_point, zero padded
	output logic                          m_tlast,   // last_of_run
	output logic [utf8dh_pkg::UserW-1:0]  m_tuser    // is_han, text_has_han, text_done
);
	import utf8dh_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             eot_s1;
	logic             skid_valid_q;
	logic [ByteW-1:0] skid_byte_q;
	logic             skid_eot_q;

	logic             s_fire;
	logic             free;
	logic             consume;
	plan_t            plan;

	assign s_tready = !skid_valid_q;
	assign s_fire   = s_tvalid && s_tready;
	assign consume  = valid_s1 && free;

	// Input register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (consume) begin
				skid_valid_q <= 1'b0;
			end
		end else if (s_fire) begin
			if (valid_s1 && !consume) begin
				skid_valid_q <= 1'b1;
			end else begin
				valid_s1 <= 1'b1;
			end
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Byte payload moves with the valid flags above.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (consume) begin
				byte_s1 <= skid_byte_q;
				eot_s1  <= skid_eot_q;
			end
		end else if (s_fire) begin
			if (valid_s1 && !consume) begin
				skid_byte_q <= s_tdata;
				skid_eot_q  <= s_tlast;
			end else begin
				byte_s1 <= s_tdata;
				eot_s1  <= s_tlast;
			end
		end
	end

	utf8dh_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (byte_s1),
		.eot       (eot_s1),
		.consume   (consume),
		.plan      (plan)
	);

	utf8dh_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (consume),
		.plan     (plan),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_decode_han_detect: random and directed texts are driven
// in, and every decoded code point is compared with an in-bench decoder model.
// Depends on utf8dh_pkg for widths and constants; needs nothing but the RTL.
module testbench;
	import utf8dh_pkg::*;

	localparam int Limit = 500000;
	localparam int HoldCycles = 400;
	localparam int DrainCycles = 5000;
	localparam int TailCycles = 20;
	localparam int RandomBytes = 400;
	localparam int PauseEvery = 8;

	// One pending input beat; a pause entry makes the sender wait for all results.
	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             eot;
		logic             pause;
	} text_beat_t;

	// One result beat as it should appear on the master side.
	typedef struct packed {
		logic [DataW-CpW-1:0] pad;
		logic [CpW-1:0]       cp;
		logic                 han;
		logic                 has_han;
		logic                 last;
		logic                 done;
	} cp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ByteW-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DataW-1:0] m_tdata;
	logic m_tlast;
	logic [UserW-1:0] m_tuser;

	text_beat_t text_beats[$];
	cp_result_t expected_cps[$];
	cp_result_t beat_results[$];

	// Decoder model state.
	int dec_taken = 0;
	int dec_len = 0;
	logic [CpW-1:0] dec_code = '0;
	logic dec_seen = 1'b0;

	int mismatches = 0;
	int cycle_count = 0;
	int tx_beats = 0;
	int tx_gap = 0;
	int stall_left = 0;
	int quiet_run[2] = '{0, 0};
	logic rx_hold = 1'b0;

	utf8_decode_han_detect u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // text_byte
		.s_tlast  (s_tlast),   // end_of_text
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // code_point, zero padded
		.m_tlast  (m_tlast),   // last_of_run
		.m_tuser  (m_tuser)    // is_han, text_has_han, text_done
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) $display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Idle length for one side; side 0 is the sender, side 1 the receiver.
	function automatic int draw_idle(input int side);
		int roll;
		if (quiet_run[side] > 0) begin
			quiet_run[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) quiet_run[side] = $urandom_range(20, 80);
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		else if (roll < 85) return $urandom_range(1, 3);
		else if (roll < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	function automatic logic in_han_block(input logic [CpW-1:0] cp);
		return (cp >= HanALo && cp <= HanAHi) || (cp >= HanULo && cp <= HanUHi) ||
		       (cp >= HanCLo && cp <= HanCHi) || (cp >= HanBLo && cp <= HanBHi);
	endfunction

	task automatic emit_cp(input logic [CpW-1:0] cp);
		cp_result_t r;
		r = '0;
		r.cp = cp;
		r.han = in_han_block(cp);
		if (r.han) dec_seen = 1'b1;
		r.has_han = dec_seen;
		beat_results.push_back(r);
	endtask

	task automatic clear_open();
		dec_taken = 0;
		dec_len = 0;
		dec_code = '0;
	endtask

	// Every byte taken so far by a broken or unfinished sequence becomes U+FFFD.
	task automatic flush_open();
		int i;
		for (i = 0; i < dec_taken; i++) emit_cp(Replacement);
		clear_open();
	endtask

	// Works out the result beats that one accepted text byte causes.
	task automatic decode_beat(input logic [ByteW-1:0] b, input logic eot);
		logic lead;
		cp_result_t r;
		beat_results.delete();
		lead = 1'b1;
		if (dec_taken > 0) begin
			if ((b & ContMask) == ContByte) begin
				lead = 1'b0;
				dec_code = {dec_code[CpW-7:0], b[5:0]};
				dec_taken++;
				if (dec_taken >= dec_len) begin
					emit_cp(dec_code);
					clear_open();
				end
			end else begin
				flush_open();
			end
		end
		if (lead) begin
			if (b[7] == 1'b0) begin
				emit_cp({{(CpW-ByteW){1'b0}}, b});
			end else if ((b & Lead2Mask) == Lead2Byte) begin
				dec_len = 2;
				dec_code = {{(CpW-5){1'b0}}, b[4:0]};
				dec_taken = 1;
			end else if ((b & Lead3Mask) == Lead3Byte) begin
				dec_len = 3;
				dec_code = {{(CpW-4){1'b0}}, b[3:0]};
				dec_taken = 1;
			end else if ((b & Lead4Mask) == Lead4Byte) begin
				dec_len = 4;
				dec_code = {{(CpW-3){1'b0}}, b[2:0]};
				dec_taken = 1;
			end else begin
				emit_cp(Replacement);
			end
		end
		if (eot && dec_taken > 0) flush_open();
		if (beat_results.size() > 0) begin
			r = beat_results.pop_back();
			r.last = 1'b1;
			r.done = eot;
			beat_results.push_back(r);
		end
		foreach (beat_results[i]) expected_cps.push_back(beat_results[i]);
		if (eot) begin
			clear_open();
			dec_seen = 1'b0;
		end
	endtask

	task automatic push_byte(input logic [ByteW-1:0] b, input logic eot);
		text_beat_t t;
		t.b = b;
		t.eot = eot;
		t.pause = 1'b0;
		text_beats.push_back(t);
	endtask

	task automatic push_pause();
		text_beat_t t;
		t = '0;
		t.pause = 1'b1;
		text_beats.push_back(t);
	endtask

	// Marks the most recent byte as the end of its text.
	task automatic end_text();
		text_beat_t t;
		t = text_beats.pop_back();
		t.eot = 1'b1;
		text_beats.push_back(t);
	endtask

	function automatic int enc_len(input logic [CpW-1:0] cp);
		if (cp < 21'h80) return 1;
		else if (cp < 21'h800) return 2;
		else if (cp < 21'h10000) return 3;
		else return 4;
	endfunction

	// Encodes a code point in the given number of bytes; short forms may be overlong.
	task automatic push_cp(input logic [CpW-1:0] cp, input int len);
		case (len)
			1: push_byte({1'b0, cp[6:0]}, 1'b0);
			2: begin
				push_byte({3'b110, cp[10:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b0);
			end
			3: begin
				push_byte({4'b1110, cp[15:12]}, 1'b0);
				push_byte({2'b10, cp[11:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b0);
			end
			default: begin
				push_byte({5'b11110, cp[20:18]}, 1'b0);
				push_byte({2'b10, cp[17:12]}, 1'b0);
				push_byte({2'b10, cp[11:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b0);
			end
		endcase
	endtask

	// Code points on and just beside the edges of the Han blocks.
	function automatic logic [CpW-1:0] han_edge(input int k);
		case (k)
			0: return HanALo - CpW'(1);
			1: return HanALo;
			2: return HanAHi;
			3: return HanAHi + CpW'(1);
			4: return HanULo - CpW'(1);
			5: return HanULo;
			6: return HanUHi;
			7: return HanUHi + CpW'(1);
			8: return HanCLo - CpW'(1);
			9: return HanCLo;
			10: return HanCHi;
			11: return HanCHi + CpW'(1);
			12: return HanBLo - CpW'(1);
			13: return HanBLo;
			14: return HanBHi;
			default: return HanBHi + CpW'(1);
		endcase
	endfunction

	// Sender: offers queued bytes and predicts each one as it is accepted.
	always @(posedge clk) begin : tx_side
		logic busy;
		text_beat_t next_beat;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				decode_beat(s_tdata, s_tlast);
				tx_beats++;
				busy = 1'b0;
			end
			if (!busy && text_beats.size() > 0) begin
				next_beat = text_beats[0];
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (next_beat.pause) begin
					if (expected_cps.size() == 0) void'(text_beats.pop_front());
				end else begin
					void'(text_beats.pop_front());
					s_tdata <= next_beat.b;
					s_tlast <= next_beat.eot;
					busy = 1'b1;
					tx_gap = draw_idle(0);
				end
			end
			s_tvalid <= busy;
		end
	end

	// Receiver: checks each result beat against the oldest expectation.
	always @(posedge clk) begin : rx_side
		logic rdy;
		cp_result_t got;
		cp_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rdy = 1'b1;
			if (m_tvalid && m_tready) begin
				got.pad = m_tdata[DataW-1:CpW];
				got.cp = m_tdata[CpW-1:0];
				got.han = m_tuser[0];
				got.has_han = m_tuser[1];
				got.done = m_tuser[2];
				got.last = m_tlast;
				if (expected_cps.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, code point %h", got.cp));
				end else begin
					want = expected_cps.pop_front();
					if (got !== want)
						report_mismatch({
							$sformatf("got pad %h cp %h han %b any %b last %b done %b",
								got.pad, got.cp, got.han, got.has_han, got.last,
								got.done),
							$sformatf(", want cp %h han %b any %b last %b done %b",
								want.cp, want.han, want.has_han, want.last,
								want.done)});
				end
				stall_left = draw_idle(1);
			end
			if (rx_hold) begin
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end
			m_tready <= rdy;
		end
	end

	// Long receiver hold-off so the block backs up and stalls its input.
	initial begin
		while (tx_beats < 120) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > Limit) begin
			$display("** utf8_decode_han_detect: FAILED **");
			$finish;
		end
	end

	// Builds the stimulus, then waits for the run to drain and reports.
	initial begin : stimulus
		int texts;
		int chars;
		int roll;
		int len;
		int k;
		int waited;
		logic [CpW-1:0] cp;

		// Zero byte, ASCII top, overlong and top 2-byte forms, a Han ideograph, bad
		// leads, and the largest 4-byte form closing the text.
		push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b0);
		push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);
		push_byte(8'hE4, 1'b0); push_byte(8'hB8, 1'b0); push_byte(8'hAD, 1'b0);
		push_byte(8'h80, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
		// Extension B start, sequences broken by ASCII and by a bad lead, then a
		// sequence still open when the text ends.
		push_byte(8'hF0, 1'b0); push_byte(8'hA0, 1'b0);
		push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'hE4, 1'b0); push_byte(8'hB8, 1'b0); push_byte(8'h41, 1'b0);
		push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0);
		push_byte(8'h80, 1'b0); push_byte(8'hF8, 1'b0);
		push_byte(8'hE3, 1'b1);
		push_pause();

		// Random texts, mostly well formed with some noise and broken sequences.
		texts = 0;
		while (text_beats.size() < 28 + RandomBytes) begin
			chars = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
			repeat (chars) begin
				roll = $urandom_range(0, 99);
				if (roll < 25) begin
					push_cp(CpW'($urandom_range(0, 8'h7F)), 1);
				end else if (roll < 40) begin
					push_cp(CpW'($urandom_range(0, 11'h7FF)), 2);
				end else if (roll < 55) begin
					push_cp(CpW'($urandom_range(0, 16'hFFFF)), 3);
				end else if (roll < 65) begin
					push_cp(CpW'($urandom_range(0, 21'h1FFFFF)), 4);
				end else if (roll < 80) begin
					cp = han_edge($urandom_range(0, 15));
					push_cp(cp, enc_len(cp));
				end else if (roll < 88) begin
					case ($urandom_range(0, 3))
						0: cp = HanALo + CpW'($urandom_range(0, HanAHi - HanALo));
						1: cp = HanULo + CpW'($urandom_range(0, HanUHi - HanULo));
						2: cp = HanCLo + CpW'($urandom_range(0, HanCHi - HanCLo));
						default: cp = HanBLo + CpW'($urandom_range(0, HanBHi - HanBLo));
					endcase
					push_cp(cp, enc_len(cp));
				end else if (roll < 94) begin
					push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
				end else begin
					// Truncated sequence: a lead and fewer continuation bytes than it needs.
					len = $urandom_range(2, 4);
					case (len)
						2: push_byte({3'b110, 5'($urandom_range(0, 31))}, 1'b0);
						3: push_byte({4'b1110, 4'($urandom_range(0, 15))}, 1'b0);
						default: push_byte({5'b11110, 3'($urandom_range(0, 7))}, 1'b0);
					endcase
					k = $urandom_range(0, len - 2);
					repeat (k) push_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
				end
			end
			end_text();
			texts++;
			if (texts % PauseEvery == 0) push_pause();
		end

		while (!arst_n) @(posedge clk);
		while (text_beats.size() > 0 || s_tvalid) @(posedge clk);
		waited = 0;
		while (expected_cps.size() > 0 && waited < DrainCycles) begin
			@(posedge clk);
			waited++;
		end
		while (expected_cps.size() > 0) begin
			cp = expected_cps[0].cp;
			report_mismatch($sformatf("missing beat, code point %h", cp));
			void'(expected_cps.pop_front());
		end
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("** utf8_decode_han_detect: PASSED **");
		else
			$display("** utf8_decode_han_detect: FAILED **");
		$finish;
	end

endmodule
